FILE: rtl/lbt_radio_pkg.sv
// Package for the listen-before-talk radio controller: mode, command and
// event codes, register indexes and register reset values.
// Depends on nothing; imported by listen_before_talk_radio_control.
`default_nettype none

package lbt_radio_pkg;

  localparam int unsigned CadCountW   = 8;
  localparam int unsigned RxCountW    = 8;
  localparam int unsigned CheckMsW    = 16;
  localparam int unsigned TimeW       = 32;
  localparam int unsigned RxLenW      = 8;
  localparam int unsigned CfgIndexW   = 2;
  localparam int unsigned CfgDataW    = 16;
  localparam int unsigned InDataW     = 48;
  localparam int unsigned OutDataW    = 8;

  localparam logic [CadCountW-1:0] CadRoundReset   = 8'd3;
  localparam logic [RxCountW-1:0]  RxRoundReset    = 8'd4;
  localparam logic [CheckMsW-1:0]  RxCheckMsReset  = 16'd100;

  // Configuration register indexes.
  localparam logic [CfgIndexW-1:0] CFG_CAD_ROUNDS = 2'd0;
  localparam logic [CfgIndexW-1:0] CFG_RX_ROUNDS  = 2'd1;
  localparam logic [CfgIndexW-1:0] CFG_RX_CHECK   = 2'd2;

  typedef enum logic [1:0] {
    ACT_POLL     = 2'd0,
    ACT_CAD_DONE = 2'd1,
    ACT_TX_DONE  = 2'd2,
    ACT_RX_PKT   = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    CMD_NONE          = 2'd0,
    CMD_START_CAD     = 2'd1,
    CMD_START_RECEIVE = 2'd2,
    CMD_TRANSMIT      = 2'd3
  } cmd_e;

  typedef enum logic [4:0] {
    MODE_IDLE         = 5'b00001,
    MODE_RECEIVE      = 5'b00010,
    MODE_CAD_STARTED  = 5'b00100,
    MODE_CAD_FINISHED = 5'b01000,
    MODE_TRANSMIT     = 5'b10000
  } mode_e;

  localparam logic [2:0] MODE_CODE_IDLE         = 3'd0;
  localparam logic [2:0] MODE_CODE_RECEIVE      = 3'd1;
  localparam logic [2:0] MODE_CODE_CAD_STARTED  = 3'd2;
  localparam logic [2:0] MODE_CODE_CAD_FINISHED = 3'd3;
  localparam logic [2:0] MODE_CODE_TRANSMIT     = 3'd4;

  // Maps the one-hot mode to the code reported on the result stream.
  function automatic logic [2:0] mode_code(mode_e mode);
    logic [2:0] code;
    case (mode)
      MODE_RECEIVE:      code = MODE_CODE_RECEIVE;
      MODE_CAD_STARTED:  code = MODE_CODE_CAD_STARTED;
      MODE_CAD_FINISHED: code = MODE_CODE_CAD_FINISHED;
      MODE_TRANSMIT:     code = MODE_CODE_TRANSMIT;
      default:           code = MODE_CODE_IDLE;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/listen_before_talk_radio_control.sv
// Listen-before-talk radio controller: one event word in, one result word out.
// An event word is held in an input register, its result in a result register;
// one word is accepted every cycle when the result side keeps up. The controller
// state registers (mode, round counts, check time, pending flag) are the only loop.
// Reset (asynchronous, active low) returns the controller to idle with all
// counters cleared and the configuration registers at their default values.
// Depends on lbt_radio_pkg.
`default_nettype none

module listen_before_talk_radio_control import lbt_radio_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // Configuration write port.
  input  wire logic                 cfg_we_i,
  input  wire logic [CfgIndexW-1:0] cfg_index_i,
  input  wire logic [CfgDataW-1:0]  cfg_data_i,
  // Event stream.
  input  wire logic                 s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  // tdata: now_ms[31:0], tx_ready[32], rx_signal[33], packet_available[34],
  //        channel_busy[35], rx_length[43:36], zero[47:44]
  input  wire logic [InDataW-1:0]   s_axis_tdata_i,
  // tuser: action[1:0]
  input  wire logic [1:0]           s_axis_tuser_i,
  // Result stream.
  output logic                      m_axis_tvalid_o,
  input  wire logic                 m_axis_tready_i,
  // tdata: radio_mode[2:0], radio_command[4:3], deliver_rx[5], zero[7:6]
  output logic [OutDataW-1:0]       m_axis_tdata_o
);

  // Input register.
  logic                 in_valid_q;
  action_e              in_action_q;
  logic [TimeW-1:0]     in_now_q;
  logic                 in_tx_ready_q, in_rx_signal_q, in_pkt_avail_q, in_busy_q;
  logic [RxLenW-1:0]    in_rx_len_q;

  // Configuration registers.
  logic [CadCountW-1:0] cfg_cad_rounds_q;
  logic [RxCountW-1:0]  cfg_rx_rounds_q;
  logic [CheckMsW-1:0]  cfg_rx_check_q;

  // Controller state.
  mode_e                mode_q, mode_d;
  logic [CadCountW-1:0] cad_left_q, cad_left_d;
  logic [RxCountW-1:0]  rx_left_q, rx_left_d;
  logic [TimeW-1:0]     last_check_q, last_check_d;
  logic                 rx_pending_q, rx_pending_d;

  // Result register.
  logic                 out_valid_q;
  logic [2:0]           out_mode_q;
  cmd_e                 out_cmd_q, cmd_d;
  logic                 out_deliver_q, deliver_d;

  logic                 advance;
  logic                 in_accept;
  mode_e                poll_mode;
  logic [TimeW-1:0]     elapsed;

  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_action_q    <= action_e'(s_axis_tuser_i);
      in_now_q       <= s_axis_tdata_i[31:0];
      in_tx_ready_q  <= s_axis_tdata_i[32];
      in_rx_signal_q <= s_axis_tdata_i[33];
      in_pkt_avail_q <= s_axis_tdata_i[34];
      in_busy_q      <= s_axis_tdata_i[35];
      in_rx_len_q    <= s_axis_tdata_i[43:36];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_cad_rounds_q <= CadRoundReset;
      cfg_rx_rounds_q  <= RxRoundReset;
      cfg_rx_check_q   <= RxCheckMsReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_CAD_ROUNDS: cfg_cad_rounds_q <= cfg_data_i[CadCountW-1:0];
        CFG_RX_ROUNDS:  cfg_rx_rounds_q  <= cfg_data_i[RxCountW-1:0];
        CFG_RX_CHECK:   cfg_rx_check_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // A pending received packet on a poll sends the controller back to idle
  // before the rest of the poll is evaluated.
  assign poll_mode = rx_pending_q ? MODE_IDLE : mode_q;
  assign elapsed   = in_now_q - last_check_q;

  always_comb begin
    mode_d       = mode_q;
    cad_left_d   = cad_left_q;
    rx_left_d    = rx_left_q;
    last_check_d = last_check_q;
    rx_pending_d = rx_pending_q;
    cmd_d        = CMD_NONE;
    deliver_d    = 1'b0;
    case (in_action_q)
      ACT_POLL: begin
        deliver_d    = rx_pending_q;
        rx_pending_d = 1'b0;
        mode_d       = poll_mode;
        case (poll_mode)
          MODE_IDLE: begin
            if (in_tx_ready_q) begin
              if (!in_rx_signal_q) begin
                mode_d     = MODE_CAD_STARTED;
                cad_left_d = cfg_cad_rounds_q;
                cmd_d      = CMD_START_CAD;
              end else begin
                mode_d    = MODE_RECEIVE;
                rx_left_d = cfg_rx_rounds_q;
              end
            end
          end
          MODE_CAD_FINISHED: begin
            if (in_pkt_avail_q) begin
              mode_d = MODE_TRANSMIT;
              cmd_d  = CMD_TRANSMIT;
            end else begin
              mode_d = MODE_IDLE;
            end
          end
          MODE_RECEIVE: begin
            // Wrapping compare on the millisecond clock.
            if (elapsed >= {{(TimeW-CheckMsW){1'b0}}, cfg_rx_check_q}) begin
              if (in_rx_signal_q) begin
                rx_left_d = cfg_rx_rounds_q;
              end else if (rx_left_q <= RxCountW'(1)) begin
                mode_d = MODE_IDLE;
              end else begin
                rx_left_d = rx_left_q - RxCountW'(1);
              end
              last_check_d = in_now_q;
            end
          end
          default: ;
        endcase
      end
      ACT_CAD_DONE: begin
        if (mode_q == MODE_CAD_STARTED) begin
          if (in_busy_q) begin
            mode_d    = MODE_RECEIVE;
            rx_left_d = cfg_rx_rounds_q;
            cmd_d     = CMD_START_RECEIVE;
          end else if (cad_left_q > CadCountW'(1)) begin
            cad_left_d = cad_left_q - CadCountW'(1);
            cmd_d      = CMD_START_CAD;
          end else begin
            mode_d = MODE_CAD_FINISHED;
          end
        end
      end
      ACT_TX_DONE: begin
        if (mode_q == MODE_TRANSMIT) begin
          mode_d = MODE_IDLE;
          cmd_d  = CMD_START_RECEIVE;
        end
      end
      ACT_RX_PKT: begin
        rx_pending_d = (in_rx_len_q != '0);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= MODE_IDLE;
      cad_left_q   <= '0;
      rx_left_q    <= '0;
      last_check_q <= '0;
      rx_pending_q <= 1'b0;
    end else if (advance) begin
      mode_q       <= mode_d;
      cad_left_q   <= cad_left_d;
      rx_left_q    <= rx_left_d;
      last_check_q <= last_check_d;
      rx_pending_q <= rx_pending_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_mode_q    <= mode_code(mode_d);
      out_cmd_q     <= cmd_d;
      out_deliver_q <= deliver_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {2'b00, out_deliver_q, out_cmd_q, out_mode_q};

  // A delivering poll always starts from idle, so it never ends in the
  // CAD finished or transmit mode.
  a_deliver_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_deliver_q |->
      (out_mode_q == MODE_CODE_IDLE) || (out_mode_q == MODE_CODE_RECEIVE) ||
      (out_mode_q == MODE_CODE_CAD_STARTED))
    else $error("deliver_rx reported with an impossible mode");

  a_tx_cmd_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_cmd_q == CMD_TRANSMIT) |-> (out_mode_q == MODE_CODE_TRANSMIT))
    else $error("transmit command without transmit mode");

  a_cad_cmd_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_cmd_q == CMD_START_CAD) |-> (out_mode_q == MODE_CODE_CAD_STARTED))
    else $error("start CAD command outside CAD started mode");

  a_advance_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("processed event word produced no result");

endmodule

`default_nettype wire
